// File: src/ryuv_pkg.sv
// Shared types and constants of the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package ryuv_pkg;

  // Pixel as it arrives on the input stream, red in the lowest byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Per-pixel results of the color math: luma and the quartered chroma terms.
  typedef struct packed {
    logic [7:0] luma;
    logic [5:0] blue_q;
    logic [5:0] red_q;
  } color_t;

  // One line-store entry: running 2x2 sums for a column pair.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] red;
  } chroma_pair_t;

  // BT.601 integer weights; chroma weights with a minus sign are kept as magnitudes.
  localparam int Y_R = 66;
  localparam int Y_G = 129;
  localparam int Y_B = 25;
  localparam int CB_R_NEG = 38;
  localparam int CB_G_NEG = 74;
  localparam int CB_B = 112;
  localparam int CR_R = 112;
  localparam int CR_G_NEG = 94;
  localparam int CR_B_NEG = 18;
  localparam int ROUND_HALF = 128;
  localparam int Y_OFFSET = 16;
  // Chroma offset of 128 pre-shifted, plus rounding: keeps the sum non-negative.
  localparam int CHROMA_BIAS = (128 << 8) + ROUND_HALF;

  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

endpackage

// File: src/rgb_to_yuv420_converter.sv
// Top level of the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

// Usage:
//  Input stream in_*: one RGB pixel per item in raster order, in_tdata =
//  {blue, green, red}. Output stream out_*: one result item per pixel with
//  that pixel's luma; on the odd pixel of an odd row out_tuser is high and
//  the item also carries the 2x2 chroma sums and the column-pair index.
//  Configuration cfg_*: write image_width (index 0) and image_height
//  (index 1) while the stream is idle; cfg_ready is always high.
//  Pipeline: an accepted pixel is held in the pixel register, then in the
//  result register, which drives out_*.
//  Throughput: one pixel per cycle while out_tready is high; the line store
//  read is issued at accept and the read-modify-write of a column pair is
//  closed when the pixel leaves the pixel register, with the last write
//  forwarded so that the two pixels of a pair may follow back to back.
//  Reset: the line store is swept to zero, one entry per cycle, over all
//  MAX_WIDTH/2 entries; in_tready stays low meanwhile. Position starts at
//  the origin, registers return to 640 x 480.
//  Stall: when out_tready is low the result register holds; the pixel
//  register can still take one more item, then in_tready drops.
module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata fields, low bit up: red[7:0], green[15:8], blue[23:16]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  // out_tdata fields, low bit up: luma[7:0], chroma_blue[15:8],
  // chroma_red[23:16], chroma_column[33:24], zero fill[39:34]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,
  // out_tuser fields, low bit up: chroma_valid[0]
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ryuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [12:0]                      cfg_data
);

  localparam int HALF_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int COL_W      = ADDR_W + 1;
  localparam int WMAX_W     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W      = ((WMAX_W > 12) ? WMAX_W : 12) + 1;
  localparam logic [CMP_W-1:0] MAX_W_EVEN = CMP_W'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HALF_DEPTH - 1);

  // Configuration and position.
  logic [11:0]      cfg_width_r;
  logic [12:0]      cfg_height_r;
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [11:0]      row_r, row_nxt, row_cur;

  // Line store clearing sweep.
  logic              clearing_r;
  logic [ADDR_W-1:0] clear_addr_r;

  // Pixel register.
  logic              s1_valid_r;
  ryuv_pkg::pixel_t  s1_px_r;
  logic [ADDR_W-1:0] s1_pair_r;
  logic              s1_odd_col_r, s1_odd_row_r;

  // Result register.
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        out_user_r;

  // Last line store write, for read-after-write on the same pair.
  logic                   fwd_valid_r;
  logic [ADDR_W-1:0]      fwd_pair_r;
  ryuv_pkg::chroma_pair_t fwd_data_r;

  logic [CMP_W-1:0] width_even, eff_w, col_ext, col_inc;
  logic [12:0]      eff_h, row_inc, row_wrap, row_plus;
  logic             in_accept, s1_move, s1_free;

  ryuv_pkg::color_t       color;
  ryuv_pkg::chroma_pair_t rd_data, old_sum, new_sum, wr_data;
  logic [8:0]             blue_add, red_add;
  logic                   fresh_group, chroma_out;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [9:0]             chroma_column;

  // Effective frame size.
  always_comb begin
    width_even = CMP_W'({cfg_width_r[11:1], 1'b0});
    if (width_even < CMP_W'(2)) begin
      eff_w = CMP_W'(2);
    end else if (width_even > MAX_W_EVEN) begin
      eff_w = MAX_W_EVEN;
    end else begin
      eff_w = width_even;
    end
    if (cfg_height_r == 13'd0) begin
      eff_h = 13'd1;
    end else if (cfg_height_r > ryuv_pkg::HEIGHT_LIMIT) begin
      eff_h = ryuv_pkg::HEIGHT_LIMIT;
    end else begin
      eff_h = cfg_height_r;
    end
  end

  // Position of the incoming pixel and the position after it.
  always_comb begin
    // Wrap first, in case the size shrank under the stored position.
    col_ext = CMP_W'(col_r);
    if (col_ext >= eff_w) begin
      col_cur = '0;
      row_inc = {1'b0, row_r} + 13'd1;
    end else begin
      col_cur = col_r;
      row_inc = {1'b0, row_r};
    end
    row_wrap = (row_inc >= eff_h) ? 13'd0 : row_inc;
    row_cur  = row_wrap[11:0];

    col_inc  = CMP_W'(col_cur) + CMP_W'(1);
    row_plus = {1'b0, row_cur} + 13'd1;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_plus >= eff_h) ? 12'd0 : row_plus[11:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end
  end

  // Handshake: the pixel register can take a new pixel in the same cycle that it empties.
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_free   = !s1_valid_r || s1_move;
  assign in_tready = s1_free && !clearing_r;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ryuv_color_math u_math (
    .px    (s1_px_r),
    .color (color)
  );

  // Read-modify-write of the column pair.
  always_comb begin
    old_sum = (fwd_valid_r && (fwd_pair_r == s1_pair_r)) ? fwd_data_r : rd_data;
    blue_add = {1'b0, old_sum.blue} + 9'(color.blue_q);
    red_add  = {1'b0, old_sum.red} + 9'(color.red_q);
    // The even pixel of an even row starts a new 2x2 group.
    fresh_group = !s1_odd_row_r && !s1_odd_col_r;
    if (fresh_group) begin
      new_sum.blue = 8'(color.blue_q);
      new_sum.red  = 8'(color.red_q);
    end else begin
      new_sum.blue = blue_add[8] ? 8'hFF : blue_add[7:0];
      new_sum.red  = red_add[8] ? 8'hFF : red_add[7:0];
    end
    chroma_out    = s1_odd_row_r && s1_odd_col_r;
    chroma_column = 10'(s1_pair_r);

    wr_en   = clearing_r || s1_move;
    wr_addr = clearing_r ? clear_addr_r : s1_pair_r;
    wr_data = clearing_r ? '0 : new_sum;
  end

  ryuv_line_store #(
    .DEPTH  (HALF_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (col_cur[COL_W-1:1]),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 12'd640;
      cfg_height_r <= 13'd480;
      col_r        <= '0;
      row_r        <= '0;
      clearing_r   <= 1'b1;
      clear_addr_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ryuv_pkg::REG_IMAGE_WIDTH) begin
          cfg_width_r <= cfg_data[11:0];
        end else if (cfg_index == ryuv_pkg::REG_IMAGE_HEIGHT) begin
          cfg_height_r <= cfg_data;
        end
      end
      if (clearing_r) begin
        if (clear_addr_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end else begin
          clear_addr_r <= clear_addr_r + ADDR_W'(1);
        end
      end
      if (in_accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        fwd_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold unless the stage advances.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r      <= ryuv_pkg::pixel_t'(in_tdata);
      s1_pair_r    <= col_cur[COL_W-1:1];
      s1_odd_col_r <= col_cur[0];
      s1_odd_row_r <= row_cur[0];
    end
    if (s1_move) begin
      fwd_pair_r <= s1_pair_r;
      fwd_data_r <= new_sum;
      out_user_r <= chroma_out;
      out_data_r <= chroma_out
                    ? {6'd0, chroma_column, new_sum.red, new_sum.blue, color.luma}
                    : {32'd0, color.luma};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The sweep runs with the pipeline empty and the input closed.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready && !s1_valid_r && !out_valid_r)
    else $error("line store sweep overlaps pixel traffic");

  // Without a chroma pair the chroma fields go out as zero.
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[39:8] == 32'd0))
    else $error("chroma fields set without chroma_valid");

  // Width is even, so an even pixel is always followed by the odd one of its pair.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !col_cur[0]) |=> col_r[0])
    else $error("column pair split by a row wrap");

endmodule

// File: src/ryuv_color_math.sv
// Per-pixel BT.601 luma and quartered chroma terms.
`timescale 1ns / 1ps

module ryuv_color_math (
  input  ryuv_pkg::pixel_t px,
  output ryuv_pkg::color_t color
);

  logic [15:0] y_sum;
  logic [8:0]  y_off;
  logic [15:0] cb_pos, cb_neg, cb_sum;
  logic [15:0] cr_pos, cr_neg, cr_sum;

  always_comb begin
    y_sum = 16'(px.red) * 16'(ryuv_pkg::Y_R) + 16'(px.green) * 16'(ryuv_pkg::Y_G)
          + 16'(px.blue) * 16'(ryuv_pkg::Y_B) + 16'(ryuv_pkg::ROUND_HALF);
    y_off = {1'b0, y_sum[15:8]} + 9'(ryuv_pkg::Y_OFFSET);

    // Biased sums never go negative, so plain unsigned subtraction is exact.
    cb_pos = 16'(ryuv_pkg::CHROMA_BIAS) + 16'(px.blue) * 16'(ryuv_pkg::CB_B);
    cb_neg = 16'(px.red) * 16'(ryuv_pkg::CB_R_NEG) + 16'(px.green) * 16'(ryuv_pkg::CB_G_NEG);
    cb_sum = cb_pos - cb_neg;
    cr_pos = 16'(ryuv_pkg::CHROMA_BIAS) + 16'(px.red) * 16'(ryuv_pkg::CR_R);
    cr_neg = 16'(px.green) * 16'(ryuv_pkg::CR_G_NEG) + 16'(px.blue) * 16'(ryuv_pkg::CR_B_NEG);
    cr_sum = cr_pos - cr_neg;

    color.luma   = y_off[8] ? 8'hFF : y_off[7:0];
    // Shift by 8, then quarter.
    color.blue_q = cb_sum[15:10];
    color.red_q  = cr_sum[15:10];
  end

endmodule

// File: src/ryuv_line_store.sv
// Line store of per-column-pair chroma sums, one write and one registered read port.
`timescale 1ns / 1ps

module ryuv_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  ryuv_pkg::chroma_pair_t wr_data,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output ryuv_pkg::chroma_pair_t rd_data
);

  ryuv_pkg::chroma_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/ryuv_scoreboard.sv
// Scoreboard for the RGB to YUV 4:2:0 converter: predicts each result item and compares it.
`timescale 1ns / 1ps

module ryuv_scoreboard #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [39:0]                      out_tdata,
  input  logic                             out_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ryuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [12:0]                      cfg_data,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int PAIRS = MAX_WIDTH / 2;

  typedef struct {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [9:0] chroma_column;
  } yuv_item_t;

  yuv_item_t   yuv_due_q[$];
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  int unsigned column_at;
  int unsigned row_at;
  logic [7:0]  blue_sum_line[PAIRS];
  logic [7:0]  red_sum_line[PAIRS];
  int          fail_tally;

  function automatic logic [7:0] sat_add8(logic [7:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 255) ? 8'hFF : s[7:0];
  endfunction

  // Advance the raster position and line store by one pixel; return its result item.
  function automatic yuv_item_t convert_pixel(ryuv_pkg::pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned pair;
    int unsigned y;
    int unsigned cbq;
    int unsigned crq;
    int          r;
    int          g;
    int          b;
    logic        odd_col;
    logic        odd_row;
    yuv_item_t   res;
    r = px.red;
    g = px.green;
    b = px.blue;
    w = {width_reg[11:1], 1'b0};
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > ryuv_pkg::HEIGHT_LIMIT) h = ryuv_pkg::HEIGHT_LIMIT;
    // geometry may have shrunk since the last pixel
    if (column_at >= w) begin
      column_at = 0;
      row_at++;
    end
    if (row_at >= h) row_at = 0;

    y = (66 * r + 129 * g + 25 * b + 128) >> 8;
    y += 16;
    if (y > 255) y = 255;
    // chroma biased by 128 << 8 so the shift acts as a floor on a non-negative value
    cbq = ((-38 * r - 74 * g + 112 * b + 128 + 32768) >> 8) >> 2;
    crq = ((112 * r - 94 * g - 18 * b + 128 + 32768) >> 8) >> 2;

    pair = (column_at >> 1) % PAIRS;
    odd_col = column_at[0];
    odd_row = row_at[0];
    if (!odd_row && !odd_col) begin
      blue_sum_line[pair] = (cbq > 255) ? 8'hFF : cbq[7:0];
      red_sum_line[pair] = (crq > 255) ? 8'hFF : crq[7:0];
    end else begin
      blue_sum_line[pair] = sat_add8(blue_sum_line[pair], cbq);
      red_sum_line[pair] = sat_add8(red_sum_line[pair], crq);
    end

    res.luma = y[7:0];
    res.chroma_valid = odd_row && odd_col;
    res.chroma_blue = res.chroma_valid ? blue_sum_line[pair] : 8'd0;
    res.chroma_red = res.chroma_valid ? red_sum_line[pair] : 8'd0;
    res.chroma_column = res.chroma_valid ? 10'((column_at >> 1) & 32'h3FF) : 10'd0;

    column_at = column_at + 1;
    if (column_at >= w) begin
      column_at = 0;
      row_at = row_at + 1;
      if (row_at >= h) row_at = 0;
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : track
    yuv_item_t want;
    if (!rst_n) begin
      width_reg = 12'd640;
      height_reg = 13'd480;
      column_at = 0;
      row_at = 0;
      for (int i = 0; i < PAIRS; i++) begin
        blue_sum_line[i] = 8'd0;
        red_sum_line[i] = 8'd0;
      end
      yuv_due_q.delete();
      fail_tally = 0;
    end else begin
      // results leave through the pixel and result registers, so compare before predicting
      if (out_tvalid && out_tready) begin
        if (yuv_due_q.size() == 0) begin
          $error("result item with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
          fail_tally++;
        end else begin
          want = yuv_due_q.pop_front();
          check_field("luma", want.luma, out_tdata[7:0]);
          check_field("chroma_valid", want.chroma_valid, out_tuser);
          check_field("chroma_blue", want.chroma_blue, out_tdata[15:8]);
          check_field("chroma_red", want.chroma_red, out_tdata[23:16]);
          check_field("chroma_column", want.chroma_column, out_tdata[33:24]);
          check_field("zero_fill", 0, out_tdata[39:34]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ryuv_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data[11:0];
        else if (cfg_index == ryuv_pkg::REG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        yuv_due_q.push_back(convert_pixel(ryuv_pkg::pixel_t'(in_tdata)));
      end
    end
    mismatches <= fail_tally;
    outstanding <= yuv_due_q.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top for the RGB to YUV 4:2:0 converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_WIDTH = 2048;
  // Receiver hold-off long enough to fill both pipeline registers and stall the input.
  localparam int HOLD_OFF_CYCLES = 400;
  // The reset sweep of the line store accepts nothing, nor does the hold-off once the input stalls.
  // Allow several times the worst quiet stretch.
  localparam int WATCHDOG_LIMIT = 5000;
  // Pixel register plus result register; wait a little longer than that.
  localparam int DRAIN_CYCLES = 8;
  // An index past the register list; the block must ignore writes to it.
  localparam logic [ryuv_pkg::CFG_INDEX_W-1:0] REG_NOT_MAPPED = 4'd9;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [23:0]                      in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [39:0]                      out_tdata;
  logic                             out_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ryuv_pkg::CFG_INDEX_W-1:0] cfg_index = ryuv_pkg::REG_IMAGE_WIDTH;
  logic [12:0]                      cfg_data = '0;

  int mismatches;
  int outstanding;
  int in_idle_pct = 31;
  int out_idle_pct = 31;
  logic hold_off_req = 1'b0;
  int held_cycles = 0;
  int quiet_cycles = 0;

  rgb_to_yuv420_converter #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ryuv_scoreboard #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off counted here once requested.
  always @(posedge clk) begin
    if (hold_off_req && held_cycles < HOLD_OFF_CYCLES) begin
      out_tready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ryuv_pkg::pixel_t rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return '{blue: b, green: g, red: r};
  endfunction

  // Mostly uniform levels, with the rails picked now and then.
  function automatic logic [7:0] pick_level();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic ryuv_pkg::pixel_t rand_pixel();
    return rgb(pick_level(), pick_level(), pick_level());
  endfunction

  // Offer one pixel, idling at random first; return at the edge that accepts it.
  task automatic push_pixel(input ryuv_pkg::pixel_t px);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 24'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted item has come back, then settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the stream drained.
  task automatic write_reg(input logic [ryuv_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(input int unsigned width, input int unsigned height, input int count);
    write_reg(ryuv_pkg::REG_IMAGE_WIDTH, width);
    write_reg(ryuv_pkg::REG_IMAGE_HEIGHT, height);
    repeat (count) push_pixel(rand_pixel());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a couple of pixels at the reset geometry of 640 x 480.
    push_pixel(rgb(8'h00, 8'h00, 8'h00));
    push_pixel(rgb(8'hFF, 8'hFF, 8'hFF));

    // Shrink to 2 x 2 mid-row: the column is past the width, so it wraps onto an odd row.
    // Then walk the primaries and secondaries through 2x2 groups, starting on that odd row.
    write_reg(ryuv_pkg::REG_IMAGE_WIDTH, 2);
    write_reg(ryuv_pkg::REG_IMAGE_HEIGHT, 2);
    push_pixel(rgb(8'hFF, 8'h00, 8'h00));
    push_pixel(rgb(8'h00, 8'hFF, 8'h00));
    push_pixel(rgb(8'h00, 8'h00, 8'hFF));
    push_pixel(rgb(8'hFF, 8'hFF, 8'h00));
    push_pixel(rgb(8'h00, 8'hFF, 8'hFF));
    push_pixel(rgb(8'hFF, 8'h00, 8'hFF));
    push_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    push_pixel(rgb(8'h00, 8'h00, 8'h00));

    // Width below two and zero height: one row of two pixels, never any chroma.
    write_reg(ryuv_pkg::REG_IMAGE_WIDTH, 1);
    write_reg(ryuv_pkg::REG_IMAGE_HEIGHT, 0);
    push_pixel(rgb(8'h80, 8'h80, 8'h80));
    push_pixel(rgb(8'h01, 8'h02, 8'h03));
    push_pixel(rgb(8'hFE, 8'hFD, 8'hFC));
    push_pixel(rgb(8'h7F, 8'h40, 8'h20));

    // Write to an unmapped index: must change nothing.
    write_reg(REG_NOT_MAPPED, 13'h1555);
    write_reg(REG_NOT_MAPPED, 13'h0AAA);
    repeat (2) push_pixel(rgb(8'hAA, 8'h55, 8'hAA));

    // Odd frame height with a small width.
    write_reg(ryuv_pkg::REG_IMAGE_WIDTH, 4);
    write_reg(ryuv_pkg::REG_IMAGE_HEIGHT, 3);
    repeat (6) push_pixel(rand_pixel());

    // Random: first frame size carries the long receiver hold-off.
    write_reg(ryuv_pkg::REG_IMAGE_WIDTH, 4);
    write_reg(ryuv_pkg::REG_IMAGE_HEIGHT, 3);
    hold_off_req <= 1'b1;
    repeat (200) push_pixel(rand_pixel());

    // A stretch with no idling on either side.
    in_idle_pct = 0;
    out_idle_pct <= 0;
    run_frame(10, 2, 300);
    in_idle_pct = 31;
    out_idle_pct <= 31;

    // All-ones registers: width clamps to the full line, height to its limit.
    run_frame(4095, 8191, 300);

    // Still mid-frame at a wide position when the geometry shrinks.
    run_frame(2, 4096, 150);
    write_reg(REG_NOT_MAPPED, 13'h1FFF);
    run_frame(6, 5, 200);
    run_frame(2048, 1, 80);
    run_frame(3, 7, 120);
    run_frame(16, 4, 200);
    repeat (4) run_frame(2 * $urandom_range(1, 12), $urandom_range(1, 9), 60);

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
